/* src/rstar_node_split_top_assert.svh */
// assertion macros for the r-star node split block
`ifndef RSTAR_NODE_SPLIT_TOP_ASSERT_SVH
`define RSTAR_NODE_SPLIT_TOP_ASSERT_SVH

// same-cycle implication under the block clock and reset
`define RSPLIT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under the block clock and reset
`define RSPLIT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rsplit_pkg.sv */
// shared types, constants and box helpers of the r-star node split block
`timescale 1ns / 1ps
`default_nettype none

package rsplit_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int MAX_DIMS    = 4;
  localparam int COORD_BITS  = 15;

  localparam int IDX_W    = $clog2(MAX_ENTRIES);
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int DIM_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int ND_W     = 3;
  localparam int MARGIN_W = 40;
  localparam int AREA_W   = COORD_BITS * MAX_DIMS;
  localparam int SUM_W    = AREA_W + 1;
  localparam int BOX_W    = 2 * MAX_DIMS * COORD_BITS;

  localparam int EIDX_W  = 6;
  localparam int FIRST_W = 7;
  localparam int AXIS_W  = 2;

  localparam int TDATA_IN_W  = ((BOX_W + 7) / 8) * 8;
  localparam int OUT_BITS    = EIDX_W + 1 + AXIS_W + 1 + FIRST_W;
  localparam int TDATA_OUT_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [ND_W-1:0] DIMS_RESET = ND_W'(2);

  // floor(2n/5) as a reciprocal multiply, exact for the entry counts in range
  localparam int FILL_MUL   = 410;
  localparam int FILL_SHIFT = 10;
  localparam int FILL_W     = CNT_W + 9;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [MAX_DIMS-1:0][COORD_BITS-1:0] corner_t;

  // lower corners sit in the low bits
  typedef struct packed {
    corner_t hi;
    corner_t lo;
  } box_t;

  typedef struct packed {
    logic              done;
    logic [AREA_W-1:0] area_a;
    logic [AREA_W-1:0] area_b;
    logic [AREA_W-1:0] overlap;
  } prod_res_t;

  function automatic coord_t extent(coord_t lo, coord_t hi);
    return (hi > lo) ? coord_t'(hi - lo) : '0;
  endfunction

  function automatic box_t box_union(box_t a, box_t b);
    box_t r;
    for (int d = 0; d < MAX_DIMS; d++) begin
      r.lo[d] = (b.lo[d] < a.lo[d]) ? b.lo[d] : a.lo[d];
      r.hi[d] = (b.hi[d] > a.hi[d]) ? b.hi[d] : a.hi[d];
    end
    return r;
  endfunction

  function automatic logic [MARGIN_W-1:0] box_margin(box_t b, logic [ND_W-1:0] nd);
    logic [MARGIN_W-1:0] s;
    s = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (ND_W'(d) < nd) begin
        s = s + MARGIN_W'(extent(b.lo[d], b.hi[d]));
      end
    end
    return s;
  endfunction

  function automatic coord_t key_of(box_t b, logic [DIM_W-1:0] d, logic up);
    return up ? b.hi[d] : b.lo[d];
  endfunction

  function automatic logic [CNT_W-1:0] min_fill(logic [CNT_W-1:0] n);
    logic [FILL_W-1:0] p;
    p = FILL_W'(n) * FILL_W'(FILL_MUL);
    return CNT_W'(p >> FILL_SHIFT);
  endfunction

endpackage

`default_nettype wire

/* src/rsplit_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module rsplit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/rsplit_prod.sv */
// shared multiplier: areas of two boxes and their overlap, one dimension a cycle
`timescale 1ns / 1ps
`default_nettype none

module rsplit_prod (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire rsplit_pkg::box_t             a_i,
  input  wire rsplit_pkg::box_t             b_i,
  input  wire logic [rsplit_pkg::ND_W-1:0]  nd_i,
  output rsplit_pkg::prod_res_t             res_o
);

  localparam int FULL_W = rsplit_pkg::AREA_W + rsplit_pkg::COORD_BITS;
  localparam logic [1:0] SEL_AREA_A = 2'd0;
  localparam logic [1:0] SEL_AREA_B = 2'd1;
  localparam logic [1:0] SEL_OVL    = 2'd2;

  logic                              busy_q, busy_d, done_q, done_d;
  logic [1:0]                        sel_q, sel_d;
  logic [rsplit_pkg::DIM_W-1:0]      k_q, k_d;
  logic [rsplit_pkg::AREA_W-1:0]     acc_q, acc_d;
  logic [rsplit_pkg::AREA_W-1:0]     area_a_q, area_a_d, area_b_q, area_b_d, ovl_q, ovl_d;
  rsplit_pkg::coord_t                term, ov_lo, ov_hi;
  logic [FULL_W-1:0]                 full;
  logic [rsplit_pkg::AREA_W-1:0]     prod;
  logic                              last_dim;

  always_comb begin
    ov_lo = (a_i.lo[k_q] > b_i.lo[k_q]) ? a_i.lo[k_q] : b_i.lo[k_q];
    ov_hi = (a_i.hi[k_q] < b_i.hi[k_q]) ? a_i.hi[k_q] : b_i.hi[k_q];
    case (sel_q)
      SEL_AREA_A: term = rsplit_pkg::extent(a_i.lo[k_q], a_i.hi[k_q]);
      SEL_AREA_B: term = rsplit_pkg::extent(b_i.lo[k_q], b_i.hi[k_q]);
      SEL_OVL:    term = rsplit_pkg::extent(ov_lo, ov_hi);
      default:    term = '0;
    endcase
    full     = FULL_W'(acc_q) * FULL_W'(term);
    prod     = full[rsplit_pkg::AREA_W-1:0];
    last_dim = (rsplit_pkg::ND_W'(k_q) == rsplit_pkg::ND_W'(nd_i - 1'b1));
  end

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    sel_d    = sel_q;
    k_d      = k_q;
    acc_d    = acc_q;
    area_a_d = area_a_q;
    area_b_d = area_b_q;
    ovl_d    = ovl_q;
    if (start_i) begin
      busy_d = 1'b1;
      sel_d  = SEL_AREA_A;
      k_d    = '0;
      acc_d  = rsplit_pkg::AREA_W'(1);
    end else if (busy_q) begin
      if (last_dim) begin
        case (sel_q)
          SEL_AREA_A: area_a_d = prod;
          SEL_AREA_B: area_b_d = prod;
          default:    ovl_d    = prod;
        endcase
        acc_d = rsplit_pkg::AREA_W'(1);
        k_d   = '0;
        if (sel_q == SEL_OVL) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          sel_d = sel_q + 2'd1;
        end
      end else begin
        acc_d = prod;
        k_d   = k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sel_q  <= SEL_AREA_A;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sel_q  <= sel_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    area_a_q <= area_a_d;
    area_b_q <= area_b_d;
    ovl_q    <= ovl_d;
  end

  assign res_o = '{done: done_q, area_a: area_a_q, area_b: area_b_q, overlap: ovl_q};

endmodule

`default_nettype wire

/* src/rstar_node_split_top.sv */
// top level of the r-star node split block
`timescale 1ns / 1ps
`default_nettype none

// R*-tree node split. Entry boxes are loaded one word per cycle; the word
// marked tlast starts the split, during which no input is taken. For N
// entries in D dimensions the split runs 2D+1 stable rank sorts (one
// compare per cycle against the corner memory), 2D+1 pairs of sweeps over
// the sorted order, m = floor(2N/5), and along the chosen order the shared
// multiplier evaluates each candidate distribution. Then the result words
// leave one at a time, each held until it is taken before the next is read,
// in arrival order, tlast on the last. One or two entries skip the split.
module rstar_node_split_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rsplit_pkg::ND_W-1:0]        cfg_wdata_i,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // low0, low1, low2, low3, high0, high1, high2, high3
  input  wire logic [rsplit_pkg::TDATA_IN_W-1:0]  s_axis_tdata_i,
  input  wire logic                               s_axis_tlast_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // entry_index, group, split_axis, by_upper, first_size, zero fill
  output logic [rsplit_pkg::TDATA_OUT_W-1:0]      m_axis_tdata_o,
  output logic                                    m_axis_tlast_o
);

  `include "rstar_node_split_top_assert.svh"

  localparam int IDX_W = rsplit_pkg::IDX_W;
  localparam int CNT_W = rsplit_pkg::CNT_W;
  localparam int DIM_W = rsplit_pkg::DIM_W;
  localparam int ND_W  = rsplit_pkg::ND_W;
  localparam int MW    = rsplit_pkg::MARGIN_W;
  localparam int SW    = rsplit_pkg::SUM_W;

  localparam logic [4:0] ST_LOAD    = 5'd0;
  localparam logic [4:0] ST_SETUP   = 5'd1;
  localparam logic [4:0] ST_SORT_RI = 5'd2;
  localparam logic [4:0] ST_SORT_KI = 5'd3;
  localparam logic [4:0] ST_SORT_CJ = 5'd4;
  localparam logic [4:0] ST_SORT_WR = 5'd5;
  localparam logic [4:0] ST_F_RO    = 5'd6;
  localparam logic [4:0] ST_F_RC    = 5'd7;
  localparam logic [4:0] ST_F_UP    = 5'd8;
  localparam logic [4:0] ST_F_AC    = 5'd9;
  localparam logic [4:0] ST_B_RO    = 5'd10;
  localparam logic [4:0] ST_B_RC    = 5'd11;
  localparam logic [4:0] ST_B_UP    = 5'd12;
  localparam logic [4:0] ST_B_AC    = 5'd13;
  localparam logic [4:0] ST_B_MUL   = 5'd14;
  localparam logic [4:0] ST_PASS    = 5'd15;
  localparam logic [4:0] ST_E_RD    = 5'd16;
  localparam logic [4:0] ST_E_OUT   = 5'd17;
  localparam logic [4:0] ST_E_WAIT  = 5'd18;

  logic [4:0]               state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d, m_q, m_d, first_q, first_d, i_q, i_d;
  logic [ND_W-1:0]          dims_q, nd_q, nd_d;
  logic [DIM_W-1:0]         d_q, d_d, axis_q, axis_d;
  logic                     key_q, key_d, up_q, up_d, final_q, final_d, special_q, special_d;
  logic [IDX_W-1:0]         j_q, j_d, rank_q, rank_d, p_q, p_d;
  rsplit_pkg::coord_t       keyi_q, keyi_d, kj;
  rsplit_pkg::box_t         box_q, box_d, sbox_q, sbox_d, pbox_q, pbox_d;
  logic [MW-1:0]            msum_q, msum_d, ml_q, ml_d, best_m_q, best_m_d, mn;
  logic [SW-1:0]            best_ov_q, best_ov_d, best_ar_q, best_ar_d, ar, ovx;
  logic                     out_valid_q, out_valid_d, out_grp_q, out_grp_d;
  logic                     out_last_q, out_last_d;
  logic [rsplit_pkg::EIDX_W-1:0] out_idx_q, out_idx_d;

  logic                     in_acc, less, step_next, prod_start;
  logic [CNT_W-1:0]         n_last, n_m, p_ext, l_ext;
  logic [DIM_W-1:0]         d_sel;
  logic                     up_sel;

  logic                     cor_we, ord_we, box_we;
  logic [IDX_W-1:0]         cor_raddr, box_waddr;
  rsplit_pkg::box_t         in_box, cor_rdata, box_rdata;
  logic [IDX_W-1:0]         ord_rdata, rank_rdata;
  rsplit_pkg::prod_res_t    prod_res;

  assign in_box = rsplit_pkg::box_t'(s_axis_tdata_i[rsplit_pkg::BOX_W-1:0]);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign n_last = count_q - 1'b1;
  assign n_m    = count_q - m_q;
  assign p_ext  = CNT_W'(p_q);
  assign l_ext  = p_ext + 1'b1;
  assign d_sel  = final_q ? axis_q : d_q;
  assign up_sel = final_q ? up_q : key_q;
  assign kj     = rsplit_pkg::key_of(cor_rdata, d_sel, up_sel);
  assign less   = (kj < keyi_q) || ((kj == keyi_q) && (j_q < i_q[IDX_W-1:0]));
  assign mn     = (ml_q < msum_q) ? ml_q : msum_q;
  assign ar     = SW'(prod_res.area_a) + SW'(prod_res.area_b);
  assign ovx    = SW'(prod_res.overlap);

  // memories
  assign cor_we    = in_acc && (count_q < CNT_W'(rsplit_pkg::MAX_ENTRIES));
  assign ord_we    = (state_q == ST_SORT_WR);
  assign box_we    = (state_q == ST_F_AC);
  assign box_waddr = p_q + 1'b1;

  always_comb begin
    case (state_q)
      ST_SORT_RI:       cor_raddr = i_q[IDX_W-1:0];
      ST_SORT_KI:       cor_raddr = j_q;
      ST_SORT_CJ:       cor_raddr = j_q + 1'b1;
      ST_F_RC, ST_B_RC: cor_raddr = ord_rdata;
      default:          cor_raddr = '0;
    endcase
  end

  rsplit_ram #(.WIDTH(rsplit_pkg::BOX_W), .DEPTH(rsplit_pkg::MAX_ENTRIES)) u_cor_ram (
    .clk_i   (clk_i),
    .we_i    (cor_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (in_box),
    .raddr_i (cor_raddr),
    .rdata_o (cor_rdata)
  );

  // sorted position -> entry
  rsplit_ram #(.WIDTH(IDX_W), .DEPTH(rsplit_pkg::MAX_ENTRIES)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (rank_q),
    .wdata_i (i_q[IDX_W-1:0]),
    .raddr_i (p_q),
    .rdata_o (ord_rdata)
  );

  // entry -> sorted position
  rsplit_ram #(.WIDTH(IDX_W), .DEPTH(rsplit_pkg::MAX_ENTRIES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (i_q[IDX_W-1:0]),
    .wdata_i (rank_q),
    .raddr_i (i_q[IDX_W-1:0]),
    .rdata_o (rank_rdata)
  );

  // prefix bounding boxes, entry l holds the box of the first l sorted entries
  rsplit_ram #(.WIDTH(rsplit_pkg::BOX_W), .DEPTH(rsplit_pkg::MAX_ENTRIES)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (box_we),
    .waddr_i (box_waddr),
    .wdata_i (box_q),
    .raddr_i (p_q),
    .rdata_o (box_rdata)
  );

  rsplit_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (prod_start),
    .a_i     (pbox_q),
    .b_i     (sbox_q),
    .nd_i    (nd_q),
    .res_o   (prod_res)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    m_d         = m_q;
    first_d     = first_q;
    i_d         = i_q;
    nd_d        = nd_q;
    d_d         = d_q;
    axis_d      = axis_q;
    key_d       = key_q;
    up_d        = up_q;
    final_d     = final_q;
    special_d   = special_q;
    j_d         = j_q;
    rank_d      = rank_q;
    p_d         = p_q;
    keyi_d      = keyi_q;
    box_d       = box_q;
    sbox_d      = sbox_q;
    pbox_d      = pbox_q;
    msum_d      = msum_q;
    ml_d        = ml_q;
    best_m_d    = best_m_q;
    best_ov_d   = best_ov_q;
    best_ar_d   = best_ar_q;
    out_valid_d = out_valid_q;
    out_grp_d   = out_grp_q;
    out_last_d  = out_last_q;
    out_idx_d   = out_idx_q;
    step_next   = 1'b0;
    prod_start  = 1'b0;

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (cor_we) begin
            count_d = count_q + 1'b1;
          end
          if (s_axis_tlast_i) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        if (dims_q == '0) begin
          nd_d = ND_W'(1);
        end else if (dims_q > ND_W'(rsplit_pkg::MAX_DIMS)) begin
          nd_d = ND_W'(rsplit_pkg::MAX_DIMS);
        end else begin
          nd_d = dims_q;
        end
        m_d     = rsplit_pkg::min_fill(count_q);
        axis_d  = '0;
        up_d    = 1'b0;
        i_d     = '0;
        if (count_q <= CNT_W'(2)) begin
          special_d = 1'b1;
          first_d   = CNT_W'(1);
          state_d   = ST_E_RD;
        end else begin
          special_d = 1'b0;
          d_d       = '0;
          key_d     = 1'b0;
          final_d   = 1'b0;
          best_m_d  = '1;
          state_d   = ST_SORT_RI;
        end
      end
      ST_SORT_RI: begin
        j_d     = '0;
        rank_d  = '0;
        state_d = ST_SORT_KI;
      end
      ST_SORT_KI: begin
        keyi_d  = rsplit_pkg::key_of(cor_rdata, d_sel, up_sel);
        state_d = ST_SORT_CJ;
      end
      ST_SORT_CJ: begin
        // read data is for j, the next read is already on its way
        rank_d = rank_q + IDX_W'(less);
        j_d    = j_q + 1'b1;
        if (CNT_W'(j_q) == n_last) begin
          state_d = ST_SORT_WR;
        end
      end
      ST_SORT_WR: begin
        i_d = i_q + 1'b1;
        if (i_q == n_last) begin
          p_d     = '0;
          msum_d  = '0;
          state_d = ST_F_RO;
        end else begin
          state_d = ST_SORT_RI;
        end
      end
      ST_F_RO: state_d = ST_F_RC;
      ST_F_RC: state_d = ST_F_UP;
      ST_F_UP: begin
        box_d   = (p_q == '0) ? cor_rdata : rsplit_pkg::box_union(box_q, cor_rdata);
        state_d = ST_F_AC;
      end
      ST_F_AC: begin
        if ((l_ext >= m_q) && (l_ext <= n_m)) begin
          msum_d = msum_q + rsplit_pkg::box_margin(box_q, nd_q);
        end
        if (l_ext == n_last) begin
          p_d     = n_last[IDX_W-1:0];
          state_d = ST_B_RO;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = ST_F_RO;
        end
      end
      ST_B_RO: state_d = ST_B_RC;
      ST_B_RC: state_d = ST_B_UP;
      ST_B_UP: begin
        sbox_d  = (p_ext == n_last) ? cor_rdata : rsplit_pkg::box_union(sbox_q, cor_rdata);
        pbox_d  = box_rdata;
        state_d = ST_B_AC;
      end
      ST_B_AC: begin
        if (p_ext <= n_m) begin
          msum_d = msum_q + rsplit_pkg::box_margin(sbox_q, nd_q);
          if (final_q) begin
            prod_start = 1'b1;
            state_d    = ST_B_MUL;
          end else begin
            step_next = 1'b1;
          end
        end else begin
          step_next = 1'b1;
        end
      end
      ST_B_MUL: begin
        if (prod_res.done) begin
          // descending split point, so ties go to the smaller one
          if ((ovx < best_ov_q) || ((ovx == best_ov_q) && (ar <= best_ar_q))) begin
            best_ov_d = ovx;
            best_ar_d = ar;
            first_d   = p_ext;
          end
          step_next = 1'b1;
        end
      end
      ST_PASS: begin
        i_d = '0;
        if (final_q) begin
          state_d = ST_E_RD;
        end else if (!key_q) begin
          ml_d    = msum_q;
          key_d   = 1'b1;
          state_d = ST_SORT_RI;
        end else begin
          if (mn < best_m_q) begin
            best_m_d = mn;
            axis_d   = d_q;
            up_d     = !(ml_q < msum_q);
          end
          key_d   = 1'b0;
          state_d = ST_SORT_RI;
          if (ND_W'(d_q) == ND_W'(nd_q - 1'b1)) begin
            final_d   = 1'b1;
            best_ov_d = '1;
            best_ar_d = '1;
            first_d   = m_q;
          end else begin
            d_d = d_q + 1'b1;
          end
        end
      end
      ST_E_RD: state_d = ST_E_OUT;
      ST_E_OUT: begin
        out_idx_d   = i_q[rsplit_pkg::EIDX_W-1:0];
        out_grp_d   = special_q ? (i_q == CNT_W'(1)) : (CNT_W'(rank_rdata) >= first_q);
        out_last_d  = (i_q == n_last);
        out_valid_d = 1'b1;
        state_d     = ST_E_WAIT;
      end
      ST_E_WAIT: begin
        if (m_axis_tready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            count_d = '0;
            state_d = ST_LOAD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_E_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase

    if (step_next) begin
      if (p_ext == m_q) begin
        state_d = ST_PASS;
      end else begin
        p_d     = p_q - 1'b1;
        state_d = ST_B_RO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      dims_q      <= rsplit_pkg::DIMS_RESET;
      out_valid_q <= 1'b0;
      best_m_q    <= '1;
      best_ov_q   <= '1;
      best_ar_q   <= '1;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      best_m_q    <= best_m_d;
      best_ov_q   <= best_ov_d;
      best_ar_q   <= best_ar_d;
      if (cfg_we_i) begin
        dims_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q       <= m_d;
    first_q   <= first_d;
    i_q       <= i_d;
    nd_q      <= nd_d;
    d_q       <= d_d;
    axis_q    <= axis_d;
    key_q     <= key_d;
    up_q      <= up_d;
    final_q   <= final_d;
    special_q <= special_d;
    j_q       <= j_d;
    rank_q    <= rank_d;
    p_q       <= p_d;
    keyi_q    <= keyi_d;
    box_q     <= box_d;
    sbox_q    <= sbox_d;
    pbox_q    <= pbox_d;
    msum_q    <= msum_d;
    ml_q      <= ml_d;
    out_grp_q <= out_grp_d;
    out_last_q <= out_last_d;
    out_idx_q <= out_idx_d;
  end

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {(rsplit_pkg::TDATA_OUT_W - rsplit_pkg::OUT_BITS)'(0),
                            first_q[rsplit_pkg::FIRST_W-1:0], up_q,
                            rsplit_pkg::AXIS_W'(axis_q), out_grp_q, out_idx_q};

  `RSPLIT_ASSERT_IMP(a_no_load_while_out, m_axis_tvalid_o, !s_axis_tready_o,
                     "input ready while a result word waits")
  `RSPLIT_ASSERT_NXT(a_run_end_clears, m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o,
                     (count_q == '0) && s_axis_tready_o, "node not cleared after last word")
  `RSPLIT_ASSERT_NXT(a_count_steps, cor_we && !s_axis_tlast_i,
                     count_q == $past(count_q) + 1'b1, "entry count did not advance")
  `RSPLIT_ASSERT_IMP(a_prod_done_expected, prod_res.done, state_q == ST_B_MUL,
                     "multiplier result outside evaluation")

endmodule

`default_nettype wire
